// ----- design/sha_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types and constants for the byte stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef enum logic {
    OP_ABSORB = 1'b0,
    OP_FINISH = 1'b1
  } op_t;

  // one queued front-end command
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    return k[t];
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage
`default_nettype wire

// ----- design/sha_cmd_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SHA command queue
// Two-entry queue between the input front end and the hashing core.
// ----------------------------------------------------------------------------
module sha_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_valid,
  output logic               wr_stall,
  input  wire sha_pkg::cmd_t wr_data,
  output logic               rd_valid,
  input  wire logic          rd_take,
  output sha_pkg::cmd_t      rd_data
);
  import sha_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr_en, rd_en;

  assign wr_stall = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid && !wr_stall;
  assign rd_en    = rd_take && rd_valid;

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end
endmodule
`default_nettype wire

// ----- design/sha_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 core
// Packs bytes, runs padding, the 64 round compression and digest output.
// ----------------------------------------------------------------------------
module sha_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  output logic               cmd_take,
  input  wire sha_pkg::cmd_t cmd,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [31:0]        out_digest_word,
  output logic [2:0]         out_word_index,
  output logic               out_last_word
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_LEN, S_ROUND, S_ADD, S_EMIT
  } state_t;

  state_t      state_r;
  logic        fin_r;       // compression belongs to a finish
  logic [5:0]  fill_r;
  logic [63:0] bits_r;
  logic [63:0] len_r;
  logic [3:0]  lcnt_r;      // length bytes written, 8 once the length is in
  logic [5:0]  t_r;
  logic [2:0]  oidx_r;
  logic [31:0] h_r   [8];
  logic [31:0] v_r   [8];
  logic [31:0] w_r   [16];
  logic [31:0] buf_r [16];

  // byte feed for this cycle
  logic       put;
  logic [7:0] pbyte;
  logic [31:0] w, x15, x2, t1, t2, s0, s1, ch, mj, g0, g1;

  assign cmd_take = (state_r == S_IDLE) && cmd_valid;

  always_comb begin
    put   = 1'b0;
    pbyte = cmd.data;
    case (state_r)
      S_IDLE: begin
        put = cmd_valid;
        pbyte = (cmd.op == OP_FINISH) ? PAD_BYTE : cmd.data;
      end
      S_PAD: begin put = 1'b1; pbyte = 8'h00; end
      S_LEN: begin put = 1'b1; pbyte = len_r[63:56]; end
      default: ;
    endcase
  end

  // round datapath, schedule word computed in the rolling window
  always_comb begin
    x15 = w_r[1];
    x2  = w_r[14];
    g0  = ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3);
    g1  = ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10);
    w   = (t_r < 6'd16) ? w_r[0] : (w_r[0] + g0 + w_r[9] + g1);
    s1  = ror(v_r[4], 6) ^ ror(v_r[4], 11) ^ ror(v_r[4], 25);
    ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1  = v_r[7] + s1 + ch + round_k(t_r) + w;
    s0  = ror(v_r[0], 2) ^ ror(v_r[0], 13) ^ ror(v_r[0], 22);
    mj  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2  = s0 + mj;
  end

  assign out_valid       = (state_r == S_EMIT);
  assign out_digest_word = h_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd7);

  // buffer write
  always_ff @(posedge clk) begin
    if (put) begin
      case (fill_r[1:0])
        2'd0: buf_r[fill_r[5:2]][31:24] <= pbyte;
        2'd1: buf_r[fill_r[5:2]][23:16] <= pbyte;
        2'd2: buf_r[fill_r[5:2]][15:8]  <= pbyte;
        default: buf_r[fill_r[5:2]][7:0] <= pbyte;
      endcase
    end
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fin_r   <= 1'b0;
      fill_r  <= '0;
      bits_r  <= '0;
      lcnt_r  <= '0;
      t_r     <= '0;
      oidx_r  <= '0;
      for (int j = 0; j < 8; j++) h_r[j] <= IV[j];
    end else begin
      if (put) fill_r <= fill_r + 6'd1;
      case (state_r)
        S_IDLE: if (cmd_valid) begin
          fin_r <= (cmd.op == OP_FINISH);
          if (cmd.op == OP_FINISH) begin
            len_r  <= bits_r;
            lcnt_r <= '0;
          end else begin
            bits_r <= bits_r + 64'd8;
          end
          if (fill_r == 6'd63) state_r <= S_ROUND;
          else if (cmd.op == OP_FINISH)
            state_r <= (fill_r == LEN_OFFSET - 6'd1) ? S_LEN : S_PAD;
          t_r <= '0;
          for (int j = 0; j < 8; j++) v_r[j] <= h_r[j];
        end
        S_PAD: begin
          t_r <= '0;
          for (int j = 0; j < 8; j++) v_r[j] <= h_r[j];
          if (fill_r == 6'd63) state_r <= S_ROUND;
          else if (fill_r == LEN_OFFSET - 6'd1) state_r <= S_LEN;
        end
        S_LEN: begin
          len_r  <= {len_r[55:0], 8'h00};
          lcnt_r <= lcnt_r + 4'd1;
          t_r    <= '0;
          for (int j = 0; j < 8; j++) v_r[j] <= h_r[j];
          if (fill_r == 6'd63) state_r <= S_ROUND;
        end
        S_ROUND: begin
          for (int j = 0; j < 15; j++) w_r[j] <= w_r[j+1];
          w_r[15] <= w;
          v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          t_r <= t_r + 6'd1;
          if (t_r == 6'd63) state_r <= S_ADD;
        end
        S_ADD: begin
          for (int j = 0; j < 8; j++) h_r[j] <= h_r[j] + v_r[j];
          oidx_r <= '0;
          if (!fin_r) state_r <= S_IDLE;
          else if (lcnt_r == 4'd8 && fill_r == 6'd0) state_r <= S_EMIT;
          else state_r <= (fill_r == LEN_OFFSET) ? S_LEN : S_PAD;
        end
        S_EMIT: if (!out_stall) begin
          oidx_r <= oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            state_r <= S_IDLE;
            fill_r  <= '0;
            bits_r  <= '0;
            for (int j = 0; j < 8; j++) h_r[j] <= IV[j];
          end
        end
        default: state_r <= S_IDLE;
      endcase
      // load window at block start
      if (state_r != S_ROUND && state_r != S_ADD && put && fill_r == 6'd63) begin
        for (int j = 0; j < 15; j++) w_r[j] <= buf_r[j];
        w_r[15] <= {buf_r[15][31:8], pbyte};
      end
    end
  end
endmodule
`default_nettype wire

// ----- design/sha256_byte_stream_hasher.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes one message at a time, one byte per input transaction.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with in_operation and in_message_byte.
// Absorb transactions add one byte; a finish transaction pads the message,
// compresses and emits eight digest words on the out_ channel, word 0 first.
// A two-entry command queue decouples the input port from the core.
// An absorb byte is packed into the block buffer; every 64th byte adds a
// compression (64 rounds, one per cycle, plus the final add), and the core
// takes no command until it is done. Finish writes the padding bytes up to
// the block end, runs one or two compressions, then emits eight digest
// words. While out_stall is high the current word holds and the core
// waits; the queue keeps taking input until it holds two transactions.
// Reset (rst_n low, synchronous) empties the queue and loads the initial
// hash values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_operation,
  input  wire logic [7:0]  in_message_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);
  import sha_pkg::*;

  cmd_t in_cmd, q_cmd;
  logic q_valid, q_take;

  assign in_cmd.op   = op_t'(in_operation);
  assign in_cmd.data = in_message_byte;

  sha_cmd_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_valid), .wr_stall(in_stall), .wr_data(in_cmd),
    .rd_valid(q_valid), .rd_take(q_take), .rd_data(q_cmd)
  );

  sha_core u_core (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(q_valid), .cmd_take(q_take), .cmd(q_cmd),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_last_word(out_last_word)
  );

  // last flag only on word seven
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd7)))
    else $error("last_word mismatch");

  // stalled output word advances not
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word_index))
    else $error("output index moved under stall");

  // core takes no command while emitting
  a_notake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !q_take)
    else $error("command taken during digest output");
endmodule
`default_nettype wire

// ----- bench/sha256_digest_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches the byte and digest channels, hashes accepted bytes with its own
// SHA-256 model and compares every digest word against the expected queue.
// ----------------------------------------------------------------------------
module sha256_digest_checker
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_operation,
  input  logic [7:0]  in_message_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_index,
  input  logic        out_last_word,
  output int          fail_count,
  output int          digests_seen
);

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] K_TABLE [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // model state
  logic [31:0]  chain [8];
  logic [31:0]  blk [16];
  logic [5:0]   fill;
  logic [63:0]  bit_count;
  digest_word_t pending_digest [$];

  function automatic logic [31:0] rotr(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] r [8];
    logic [31:0] w [64];
    logic [31:0] t1, t2;
    for (int j = 0; j < 8; j++) r[j] = chain[j];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) w[t] = blk[t];
      else w[t] = w[t-16] + w[t-7]
        + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
        + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
      t1 = r[7] + (rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25))
         + ((r[4] & r[5]) ^ (~r[4] & r[6])) + K_TABLE[t] + w[t];
      t2 = (rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22))
         + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
      r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
      r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) chain[j] += r[j];
  endtask

  task automatic append_byte(logic [7:0] b);
    blk[fill[5:2]][(3 - fill[1:0]) * 8 +: 8] = b;
    fill = fill + 6'd1;
    if (fill == 6'd0) compress();
  endtask

  task automatic restart_message();
    for (int j = 0; j < 8; j++) chain[j] = IV[j];
    fill = '0;
    bit_count = '0;
  endtask

  // pad, compress and queue the eight digest words
  task automatic finish_message();
    logic [63:0] len;
    digest_word_t d;
    len = bit_count;
    append_byte(PAD_BYTE);
    while (fill != LEN_OFFSET) append_byte(8'h00);
    for (int i = 0; i < 8; i++) append_byte(len[56 - 8 * i +: 8]);
    for (int i = 0; i < 8; i++) begin
      d.word = chain[i];
      d.index = 3'(i);
      d.last = (i == 7);
      pending_digest.push_back(d);
    end
    restart_message();
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    digests_seen = 0;
    restart_message();
    for (int j = 0; j < 16; j++) blk[j] = '0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_message();
      pending_digest.delete();
    end else begin
      // input transaction
      if (in_valid && !in_stall) begin
        if (op_t'(in_operation) == OP_FINISH) finish_message();
        else begin
          append_byte(in_message_byte);
          bit_count = bit_count + 64'd8;
        end
      end
      // output transaction
      if (out_valid && !out_stall) begin
        if (pending_digest.size() == 0) begin
          report_mismatch("unexpected digest word", out_digest_word, '0);
        end else begin
          digest_word_t e;
          e = pending_digest.pop_front();
          if (out_digest_word !== e.word) report_mismatch("digest_word", out_digest_word, e.word);
          if (out_word_index !== e.index) report_mismatch("word_index", 32'(out_word_index), 32'(e.index));
          if (out_last_word !== e.last) report_mismatch("last_word", 32'(out_last_word), 32'(e.last));
          if (e.last) digests_seen++;
        end
      end
    end
  end

  function automatic int outstanding();
    return pending_digest.size();
  endfunction

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher testbench
// Drives messages of random length and content through the hasher under
// varied sender and receiver idling; the checker predicts the digests.
// ----------------------------------------------------------------------------
module tb;
  import sha_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_operation = OP_ABSORB;
  logic [7:0]  in_message_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;
  int          fail_count;
  int          digests_seen;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int bytes_sent = 0;
  int finishes_sent = 0;

  always #6 clk = ~clk;

  sha256_byte_stream_hasher DUT (.*);

  sha256_digest_checker u_checker (.*);

  // receiver stall, random or held
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // offer one transaction and wait for it to be taken; valid stays up
  // until the next transaction or idle cycle replaces it
  task automatic send_txn(op_t op, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_message_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (op == OP_FINISH) finishes_sent++;
    else bytes_sent++;
  endtask

  task automatic send_message(int len, int pattern);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (pattern)
        0: b = 8'h00;
        1: b = 8'hff;
        default: b = 8'($urandom);
      endcase
      send_txn(OP_ABSORB, b);
    end
    send_txn(OP_FINISH, 8'($urandom));
  endtask

  task automatic set_idling(int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
      default: begin send_idle_pct = 32; recv_stall_pct = 32; end
    endcase
  endtask

  // long receiver hold-off while the sender keeps offering
  initial begin
    wait (finishes_sent == 3);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #30ms;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int n;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed: empty message, finish with a set byte, short messages
    send_txn(OP_FINISH, 8'hff);
    send_message(1, 1);
    send_message(3, 2);
    send_txn(OP_ABSORB, 8'h00);
    send_txn(OP_ABSORB, 8'hff);
    send_txn(OP_FINISH, 8'h00);
    send_message(5, 2);
    send_message(4, 0);
    // random: mostly short messages, a few across block boundaries
    for (int phase = 0; bytes_sent + finishes_sent < 400; phase++) begin
      set_idling(phase);
      for (int m = 0; m < 2 && bytes_sent + finishes_sent < 400; m++) begin
        case ($urandom_range(9))
          0: n = 55 + $urandom_range(10);
          1: n = 119 + $urandom_range(10);
          default: n = $urandom_range(20);
        endcase
        send_message(n, 2);
      end
    end
    in_valid <= 1'b0;
    // drain
    while (u_checker.outstanding() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d bytes in %0d messages, %0d digests compared",
             bytes_sent, finishes_sent, digests_seen);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
